/* design/rgb_luma_histogram_normalizer_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the luma and RGB histogram block
// Concurrent checks that vanish when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef RGB_LUMA_HISTOGRAM_NORMALIZER_DEFINES_SVH
`define RGB_LUMA_HISTOGRAM_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define RLHN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RLHN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RLHN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RLHN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/rlhn_pkg.sv */
// -----------------------------------------------------------------------------
// Histogram block package
// Shared widths, codes, state types and structs.
// -----------------------------------------------------------------------------
`default_nettype none
package rlhn_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int BIN_COUNT   = 256;
    localparam int BIN_BITS    = $clog2(BIN_COUNT);
    localparam int CHANNELS    = 4;
    localparam int CH_BITS     = $clog2(CHANNELS);
    localparam int LEVEL_BITS  = 16;
    localparam int RAW_BITS    = 24;
    localparam int QUO_BITS    = 31;
    localparam int DIV_STEPS   = 30;
    localparam int SQRT_STEPS  = 16;
    localparam int STEP_BITS   = 5;
    localparam int SQ_BITS     = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    localparam int LUMA_WR     = 2126;
    localparam int LUMA_WG     = 7152;
    localparam int LUMA_WB     = 722;
    localparam int LUMA_HALF   = 5000;
    localparam int LUMA_DIV    = 10000;
    localparam int LUMA_RECIP  = 107374;
    localparam int LUMA_SHIFT  = 30;
    localparam int LUMA_MAX    = 255;
    localparam int SUM_BITS    = 22;

    localparam logic [CH_BITS-1:0] CH_LUMA  = 2'd0;
    localparam logic [CH_BITS-1:0] CH_RED   = 2'd1;
    localparam logic [CH_BITS-1:0] CH_GREEN = 2'd2;
    localparam logic [CH_BITS-1:0] CH_BLUE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_command;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LUMA,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_NORM,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        NS_IDLE,
        NS_DIV,
        NS_SQRT,
        NS_DONE
    } t_norm_state;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] maximum;
    } t_norm_req;

    typedef struct packed {
        logic                  done;
        logic [LEVEL_BITS-1:0] level;
    } t_norm_rsp;

endpackage
`default_nettype wire

/* design/rlhn_if.sv */
// -----------------------------------------------------------------------------
// Histogram block channel interfaces
// Valid/ready channels for command transactions and read results.
// -----------------------------------------------------------------------------
`default_nettype none
interface rlhn_in_if import rlhn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [CH_BITS-1:0]  channel;
    logic [BIN_BITS-1:0] bin;

    modport source (output valid, command, red, green, blue, channel, bin, input ready);
    modport sink   (input valid, command, red, green, blue, channel, bin, output ready);
endinterface

interface rlhn_out_if import rlhn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;
    logic [RAW_BITS-1:0]   raw_count;

    modport source (output valid, level, raw_count, input ready);
    modport sink   (input valid, level, raw_count, output ready);
endinterface
`default_nettype wire

/* design/rlhn_ram.sv */
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module rlhn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/rlhn_luma.sv */
// -----------------------------------------------------------------------------
// Luma pipeline
// Three stages: weighted sum, reciprocal quotient estimate, correction.
// -----------------------------------------------------------------------------
`default_nettype none
module rlhn_luma import rlhn_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [7:0]          i_red,
    input  wire logic [7:0]          i_green,
    input  wire logic [7:0]          i_blue,
    output logic                     o_valid,
    output logic      [BIN_BITS-1:0] o_luma
);

    logic [2:0]          r_vld;
    logic [SUM_BITS-1:0] r_sum1;
    logic [SUM_BITS-1:0] r_sum2;
    logic [8:0]          r_q;
    logic [BIN_BITS-1:0] r_luma;

    logic [SUM_BITS-1:0] n_sum;
    logic [SUM_BITS+16:0] prod;
    logic [SUM_BITS:0]   back;
    logic [SUM_BITS:0]   rem;
    logic [9:0]          q_fix;

    always_comb begin
        n_sum = SUM_BITS'(LUMA_WR) * SUM_BITS'(i_red)
              + SUM_BITS'(LUMA_WG) * SUM_BITS'(i_green)
              + SUM_BITS'(LUMA_WB) * SUM_BITS'(i_blue)
              + SUM_BITS'(LUMA_HALF);
        prod  = (SUM_BITS+17)'(r_sum1) * (SUM_BITS+17)'(LUMA_RECIP);
        back  = (SUM_BITS+1)'(r_q) * (SUM_BITS+1)'(LUMA_DIV);
        rem   = {1'b0, r_sum2} - back;
        q_fix = (rem >= (SUM_BITS+1)'(LUMA_DIV)) ? {1'b0, r_q} + 10'd1 : {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum1 <= n_sum;
        r_sum2 <= r_sum1;
        r_q    <= prod[LUMA_SHIFT+8:LUMA_SHIFT];
        r_luma <= (q_fix > 10'(LUMA_MAX)) ? BIN_BITS'(LUMA_MAX) : q_fix[BIN_BITS-1:0];
    end

    assign o_valid = r_vld[2];
    assign o_luma  = r_luma;

endmodule
`default_nettype wire

/* design/rlhn_norm.sv */
// -----------------------------------------------------------------------------
// Normalized level unit
// Restoring division of count by maximum, then a bit-serial square root.
// -----------------------------------------------------------------------------
`default_nettype none
module rlhn_norm import rlhn_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_norm_req i_req,
    output t_norm_rsp      o_rsp
);

    t_norm_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_max;
    logic [COUNT_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0]   r_quo;
    logic [SQ_BITS-1:0]    r_x;
    logic [SQ_BITS-1:0]    r_root;
    logic [SQ_BITS-1:0]    r_bit;
    logic [STEP_BITS-1:0]  r_step;
    logic [LEVEL_BITS-1:0] r_level;

    logic [COUNT_BITS:0]   rem2;
    logic                  div_ge;
    logic [COUNT_BITS:0]   rem_sub;
    logic [QUO_BITS-1:0]   n_quo;
    logic                  start_ge;
    logic [SQ_BITS-1:0]    trial;
    logic                  sq_ge;
    logic [SQ_BITS-1:0]    n_root;

    always_comb begin
        rem2     = {r_rem, 1'b0};
        div_ge   = rem2 >= {1'b0, r_max};
        rem_sub  = rem2 - {1'b0, r_max};
        n_quo    = {r_quo[QUO_BITS-2:0], div_ge};
        start_ge = i_req.count >= i_req.maximum;
        trial    = r_root + r_bit;
        sq_ge    = r_x >= trial;
        n_root   = sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            NS_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.maximum == '0) ? NS_DONE : NS_DIV;
                end
            end
            NS_DIV: begin
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = NS_SQRT;
                end
            end
            NS_SQRT: begin
                if (r_step == STEP_BITS'(SQRT_STEPS - 1)) begin
                    n_state = NS_DONE;
                end
            end
            NS_DONE: begin
                n_state = NS_IDLE;
            end
            default: begin
                n_state = NS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == NS_DONE);
        o_rsp.level = r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            NS_IDLE: begin
                r_max   <= i_req.maximum;
                r_rem   <= start_ge ? i_req.count - i_req.maximum : i_req.count;
                r_quo   <= {{(QUO_BITS-1){1'b0}}, start_ge};
                r_step  <= '0;
                r_level <= '0;
            end
            NS_DIV: begin
                r_rem <= div_ge ? rem_sub[COUNT_BITS-1:0] : rem2[COUNT_BITS-1:0];
                r_quo <= n_quo;
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                    r_x    <= SQ_BITS'(n_quo);
                    r_root <= '0;
                    r_bit  <= SQ_BITS'(1) << (QUO_BITS - 1);
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            NS_SQRT: begin
                if (sq_ge) begin
                    r_x <= r_x - trial;
                end
                r_root  <= n_root;
                r_bit   <= r_bit >> 2;
                r_step  <= r_step + 1'b1;
                r_level <= n_root[LEVEL_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/rgb_luma_histogram_normalizer.sv */
// -----------------------------------------------------------------------------
// Luma and RGB histogram with normalized readout
// Four 256-bin histograms kept in block RAM, read-modify-write per pixel.
// -----------------------------------------------------------------------------
// The block takes one command transaction at a time. A pixel add passes from
// acceptance through the luma pipeline, the RAM read and the write back of
// all four bins, then returns to idle for the next acceptance. A bin read,
// unless the channel maximum is zero, runs the one-bit-per-cycle division of
// count by the channel maximum (an initial compare and 30 steps) and the
// square root (16 steps); its result waits in an output register while new
// commands are taken. A clear command, and also reset, runs a clearing pass
// over all 256 bin addresses, one per cycle, during which no command is
// accepted.
`default_nettype none
`include "rgb_luma_histogram_normalizer_defines.svh"
module rgb_luma_histogram_normalizer import rlhn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rlhn_in_if.sink    i_req,
    rlhn_out_if.source o_res
);

    t_state r_state, n_state;

    logic [7:0]            r_red;
    logic [7:0]            r_green;
    logic [7:0]            r_blue;
    logic [CH_BITS-1:0]    r_channel;
    logic [BIN_BITS-1:0]   r_bin;
    logic [BIN_BITS-1:0]   r_luma;
    logic [BIN_BITS-1:0]   r_clr_addr;
    logic [COUNT_BITS-1:0] r_max [CHANNELS];
    logic [COUNT_BITS-1:0] r_count;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    logic [RAW_BITS-1:0]   r_out_raw;

    logic                  accept;
    logic                  out_load;
    logic                  luma_valid;
    logic [BIN_BITS-1:0]   luma;
    logic                  mem_we;
    logic [BIN_BITS-1:0]   pix_addr [CHANNELS];
    logic [BIN_BITS-1:0]   raddr    [CHANNELS];
    logic [BIN_BITS-1:0]   waddr    [CHANNELS];
    logic [COUNT_BITS-1:0] wdata    [CHANNELS];
    logic [COUNT_BITS-1:0] rdata    [CHANNELS];
    logic [COUNT_BITS-1:0] inc      [CHANNELS];
    logic [COUNT_BITS+RAW_BITS-1:0] count_ext;
    t_norm_req             norm_req;
    t_norm_rsp             norm_rsp;

    assign accept    = i_req.valid && i_req.ready;
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || o_res.ready);
    assign count_ext = {{RAW_BITS{1'b0}}, r_count};

    rlhn_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept && (i_req.command == CMD_ADD)),
        .i_red   (i_req.red),
        .i_green (i_req.green),
        .i_blue  (i_req.blue),
        .o_valid (luma_valid),
        .o_luma  (luma)
    );

    always_comb begin
        pix_addr[CH_LUMA]  = r_luma;
        pix_addr[CH_RED]   = r_red;
        pix_addr[CH_GREEN] = r_green;
        pix_addr[CH_BLUE]  = r_blue;
        mem_we = (r_state == ST_PIX_WR) || (r_state == ST_CLEAR);
        for (int c = 0; c < CHANNELS; c++) begin
            raddr[c] = (r_state == ST_PIX_RD) ? pix_addr[c] : r_bin;
            inc[c]   = (rdata[c] == COUNT_LIMIT) ? rdata[c] : rdata[c] + 1'b1;
            waddr[c] = (r_state == ST_CLEAR) ? r_clr_addr : pix_addr[c];
            wdata[c] = (r_state == ST_CLEAR) ? '0 : inc[c];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
        rlhn_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (BIN_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (mem_we),
            .i_waddr (waddr[c]),
            .i_wdata (wdata[c]),
            .i_raddr (raddr[c]),
            .o_rdata (rdata[c])
        );
    end

    always_comb begin
        norm_req.start   = (r_state == ST_RD_DATA);
        norm_req.count   = rdata[r_channel];
        norm_req.maximum = r_max[r_channel];
    end

    rlhn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_rsp   (norm_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BIN_BITS'(BIN_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_command'(i_req.command))
                        CMD_ADD:   n_state = ST_LUMA;
                        CMD_READ:  n_state = ST_RD_ADDR;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LUMA: begin
                if (luma_valid) begin
                    n_state = ST_PIX_RD;
                end
            end
            ST_PIX_RD:  n_state = ST_PIX_WR;
            ST_PIX_WR:  n_state = ST_IDLE;
            ST_RD_ADDR: n_state = ST_RD_DATA;
            ST_RD_DATA: n_state = ST_NORM;
            ST_NORM: begin
                if (norm_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready     = (r_state == ST_IDLE);
        o_res.valid     = r_out_valid;
        o_res.level     = r_out_level;
        o_res.raw_count = r_out_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_max[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    r_max[c] <= '0;
                end
            end else begin
                r_clr_addr <= '0;
            end
            if (r_state == ST_PIX_WR) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (inc[c] > r_max[c]) begin
                        r_max[c] <= inc[c];
                    end
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red     <= i_req.red;
            r_green   <= i_req.green;
            r_blue    <= i_req.blue;
            r_channel <= i_req.channel;
            r_bin     <= i_req.bin;
        end
        if (luma_valid) begin
            r_luma <= luma;
        end
        if (r_state == ST_RD_DATA) begin
            r_count <= rdata[r_channel];
        end
        if (norm_rsp.done) begin
            r_level <= norm_rsp.level;
        end
        if (out_load) begin
            r_out_level <= r_level;
            r_out_raw   <= count_ext[RAW_BITS-1:0];
        end
    end

    `RLHN_ASSERT_IMPL(a_we_state, i_clk, i_rst_n, mem_we, (r_state == ST_PIX_WR) || (r_state == ST_CLEAR))
    `RLHN_ASSERT_IMPL(a_norm_done, i_clk, i_rst_n, norm_rsp.done, r_state == ST_NORM)
    `RLHN_ASSERT_NEXT(a_max_cover, i_clk, i_rst_n, r_state == ST_PIX_WR, r_max[CH_LUMA] >= $past(wdata[CH_LUMA]))

endmodule
`default_nettype wire

/* tb/sv/rgb_luma_histogram_normalizer_test.sv */
// -----------------------------------------------------------------------------
// Luma and RGB histogram testbench
// Drives add, read, clear and unused-code commands with random gaps on both
// channels, predicts every read result from a local copy of the histograms,
// and checks each result transaction against the oldest prediction.
// -----------------------------------------------------------------------------
`default_nettype none

class hist_scoreboard;
    logic [23:0] counts[4][256];
    logic [23:0] peak[4];
    logic [15:0] exp_level[$];
    logic [23:0] exp_raw[$];
    int mismatches;

    function new();
        mismatches = 0;
        wipe();
    endfunction

    function void wipe();
        for (int c = 0; c < 4; c++) begin
            peak[c] = '0;
            for (int b = 0; b < 256; b++) counts[c][b] = '0;
        end
    endfunction

    function void bump(int c, int b);
        if (counts[c][b] != 24'hFFFFFF) counts[c][b] = counts[c][b] + 1;
        if (counts[c][b] > peak[c]) peak[c] = counts[c][b];
    endfunction

    function logic [31:0] root_of(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r[31:0];
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [1:0] ch, logic [7:0] bn);
        int sum;
        int luma;
        logic [63:0] q;
        logic [31:0] lv;
        if (cmd == rlhn_pkg::CMD_ADD) begin
            sum = 2126 * r + 7152 * g + 722 * b;
            luma = (sum + 5000) / 10000;
            if (luma > 255) luma = 255;
            bump(0, luma);
            bump(1, r);
            bump(2, g);
            bump(3, b);
        end else if (cmd == rlhn_pkg::CMD_READ) begin
            lv = 0;
            if (peak[ch] != 0) begin
                q = ({40'd0, counts[ch][bn]} << 30) / {40'd0, peak[ch]};
                lv = root_of(q);
            end
            exp_level.push_back(lv[15:0]);
            exp_raw.push_back(counts[ch][bn]);
        end else if (cmd == rlhn_pkg::CMD_CLEAR) begin
            wipe();
        end
    endfunction

    function void check_result(logic [15:0] lv, logic [23:0] raw);
        logic [15:0] el;
        logic [23:0] er;
        if (exp_level.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result level=%0d raw=%0d", lv, raw);
            return;
        end
        el = exp_level.pop_front();
        er = exp_raw.pop_front();
        if (lv !== el || raw !== er) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected level=%0d raw=%0d, got level=%0d raw=%0d",
                         el, er, lv, raw);
        end
    endfunction

    function int pending();
        return exp_level.size();
    endfunction
endclass

module rgb_luma_histogram_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rlhn_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    bit sink_on = 1'b0;
    hist_scoreboard sb = new();

    rlhn_in_if  req ();
    rlhn_out_if res ();

    rgb_luma_histogram_normalizer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_res  (res.source)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && res.valid && res.ready) sb.check_result(res.level, res.raw_count);
    end

    // Result side: a random ready stall before each result transaction.
    initial begin
        int gap;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_on) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                res.ready <= 1'b1;
                @(posedge i_clk);
                while (!res.valid) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [1:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                        logic [1:0] ch, logic [7:0] bn, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.red <= r;
        req.green <= g;
        req.blue <= b;
        req.channel <= ch;
        req.bin <= bn;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        sb.note_input(cmd, r, g, b, ch, bn);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic rand_pixel(bit burst);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1))
            send(CMD_ADD, base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                 base ^ 8'($urandom_range(0, 3)), 2'($urandom), 8'($urandom), burst);
        else
            send(CMD_ADD, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                 8'($urandom), burst);
    endtask

    initial begin
        int pick;
        bit burst;
        req.valid = 1'b0;
        req.command = CMD_ADD;
        req.red = '0;
        req.green = '0;
        req.blue = '0;
        req.channel = '0;
        req.bin = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;

        send(CMD_READ, 0, 0, 0, CH_LUMA, 0, 0);
        send(CMD_READ, 0, 0, 0, CH_BLUE, 255, 0);
        send(CMD_ADD, 0, 0, 0, 0, 0, 0);
        send(CMD_ADD, 255, 255, 255, 3, 255, 0);
        send(CMD_ADD, 255, 0, 0, 0, 0, 1);
        send(CMD_ADD, 0, 255, 0, 0, 0, 1);
        send(CMD_ADD, 0, 0, 255, 0, 0, 1);
        send(CMD_ADD, 255, 255, 255, 0, 0, 1);
        send(CMD_ADD, 1, 2, 4, 0, 0, 0);
        send(2'd3, 8'hAA, 8'h55, 8'hF0, 2'd3, 8'hFF, 0);
        send(CMD_READ, 0, 0, 0, CH_LUMA, 255, 0);
        send(CMD_READ, 0, 0, 0, CH_RED, 255, 0);
        send(CMD_READ, 0, 0, 0, CH_GREEN, 0, 1);
        send(CMD_READ, 0, 0, 0, CH_BLUE, 4, 1);
        send(CMD_READ, 0, 0, 0, CH_LUMA, 100, 0);
        drain();
        send(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, CH_RED, 255, 0);
        drain();

        for (int i = 0; i < 1300; i++) begin
            burst = ($urandom_range(0, 9) < 3);
            pick = $urandom_range(0, 99);
            if (pick < 70) rand_pixel(burst);
            else if (pick < 95)
                send(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     8'($urandom_range(0, 1) ? $urandom : $urandom_range(120, 135)), burst);
            else if (pick < 97)
                send(2'd3, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     8'($urandom), 0);
            else begin
                drain();
                send(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     8'($urandom), 0);
            end
            if (i == 650) drain();
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/rlhn_pkg.sv
design/rlhn_if.sv
design/rlhn_ram.sv
design/rlhn_luma.sv
design/rlhn_norm.sv
design/rgb_luma_histogram_normalizer.sv
tb/sv/rgb_luma_histogram_normalizer_test.sv
